[sv/process_priority_queue_core_defines.svh]
// Assertion helpers shared by the queue RTL.
`ifndef PROCESS_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define PROCESS_PRIORITY_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define PPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only out of reset.
`define PPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/ppq_pkg.sv]
package ppq_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int HANDLE_BITS   = 16;
  localparam int PRIORITY_BITS = 8;

  // Slot index width and occupancy width (occupancy can equal the depth).
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_FULL     = 2'd1,
    ST_DEQUEUED = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_t;

  // One stored slot: handle in the upper bits, priority in the lower bits.
  typedef struct packed {
    logic [HANDLE_BITS-1:0]   handle;
    logic [PRIORITY_BITS-1:0] prio;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Control from the sequencer to the minimum search unit.
  typedef struct packed {
    logic             vld;
    logic             first;
    logic [IDX_W-1:0] idx;
  } min_ctl_t;

endpackage

[sv/process_priority_queue_core.sv]
// Bounded process queue with a priority mode and a FIFO mode.
// Requests enter on start/in_* and are taken at a clock edge where start is
// high and busy is low. Opcode enqueue appends a handle and its priority at
// the tail; opcode dequeue removes the lowest-priority entry nearest the head
// (cfg_fifo_mode low) or the head entry (cfg_fifo_mode high).
// Every request yields exactly one result, shown on out_* for one cycle with
// out_valid high. The receiver cannot stall; the result must be taken then.
// An enqueue, a full drop or an empty dequeue reports in the cycle after
// the request, and a new request is taken in that very cycle. A
// dequeue in priority mode reads every held slot once through the single
// read port of the slot memory to find the minimum, then reads and rewrites
// each later slot to close the gap. In FIFO mode the search reads only the
// head. busy stays high for the whole dequeue.
// cfg_fifo_mode is written with cfg_valid; cfg_ready is always high. The user
// must change the mode only while no request is in flight; it is unchecked.
// Synchronous active-low reset empties the queue and selects priority mode.
// Slot contents are not cleared; only slots below the occupancy are read.
`include "process_priority_queue_core_defines.svh"

module process_priority_queue_core
  import ppq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_opcode,
  input  logic [HANDLE_BITS-1:0]   in_process_handle,
  input  logic [PRIORITY_BITS-1:0] in_process_priority,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_fifo_mode,
  output logic                     out_valid,
  output logic [1:0]               out_status,
  output logic [HANDLE_BITS-1:0]   out_handle,
  output logic [PRIORITY_BITS-1:0] out_priority,
  output logic [CNT_W-1:0]         out_entry_count
);

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic             fifo_mode_r;

  // Search and shift pointers count up to the depth, so they carry CNT_W bits.
  logic [CNT_W-1:0] scan_idx_r, scan_idx_nxt;
  logic [CNT_W-1:0] scan_n_r, scan_n_nxt;
  logic [CNT_W-1:0] sh_rd_r, sh_rd_nxt;

  // Read data from the slot memory is registered and arrives in the cycle after the address.
  logic             rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;

  logic                     out_valid_r, out_valid_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic [HANDLE_BITS-1:0]   out_handle_r, out_handle_nxt;
  logic [PRIORITY_BITS-1:0] out_priority_r, out_priority_nxt;
  logic [CNT_W-1:0]         out_count_r, out_count_nxt;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata, ram_rdata;

  min_ctl_t         min_ctl;
  entry_t           best;
  logic [IDX_W-1:0] best_idx;

  logic accept;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  ppq_ram #(
    .DATA_W (ENTRY_W),
    .DEPTH  (QUEUE_DEPTH),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The compare unit only sees slot data during the minimum search.
  assign min_ctl.vld   = rd_vld_r && (state_r == S_SCAN);
  assign min_ctl.first = (rd_idx_r == '0);
  assign min_ctl.idx   = rd_idx_r;

  ppq_min_unit u_min (
    .clk      (clk),
    .ctl      (min_ctl),
    .data     (ram_rdata),
    .best     (best),
    .best_idx (best_idx)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fifo_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      fifo_mode_r <= cfg_fifo_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r     <= scan_idx_nxt;
    scan_n_r       <= scan_n_nxt;
    sh_rd_r        <= sh_rd_nxt;
    rd_idx_r       <= rd_idx_nxt;
    out_status_r   <= out_status_nxt;
    out_handle_r   <= out_handle_nxt;
    out_priority_r <= out_priority_nxt;
    out_count_r    <= out_count_nxt;
  end

  always_comb begin
    state_nxt        = state_r;
    occ_nxt          = occ_r;
    scan_idx_nxt     = scan_idx_r;
    scan_n_nxt       = scan_n_r;
    sh_rd_nxt        = sh_rd_r;
    rd_vld_nxt       = 1'b0;
    rd_idx_nxt       = rd_idx_r;
    out_valid_nxt    = 1'b0;
    out_status_nxt   = out_status_r;
    out_handle_nxt   = out_handle_r;
    out_priority_nxt = out_priority_r;
    out_count_nxt    = out_count_r;
    ram_we           = 1'b0;
    ram_waddr        = '0;
    ram_wdata        = ram_rdata;
    ram_re           = 1'b0;
    ram_raddr        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (opcode_t'(in_opcode) == OP_ENQ) begin
            // Enqueue finishes right here: write the tail slot unless full, and report.
            out_valid_nxt    = 1'b1;
            out_handle_nxt   = '0;
            out_priority_nxt = '0;
            if (occ_r < CNT_W'(QUEUE_DEPTH)) begin
              ram_we           = 1'b1;
              ram_waddr        = occ_r[IDX_W-1:0];
              ram_wdata.handle = in_process_handle;
              ram_wdata.prio   = in_process_priority;
              occ_nxt          = occ_r + CNT_W'(1);
              out_status_nxt   = ST_ENQUEUED;
              out_count_nxt    = occ_r + CNT_W'(1);
            end else begin
              out_status_nxt = ST_FULL;
              out_count_nxt  = occ_r;
            end
          end else if (occ_r == '0) begin
            out_valid_nxt    = 1'b1;
            out_status_nxt   = ST_EMPTY;
            out_handle_nxt   = '0;
            out_priority_nxt = '0;
            out_count_nxt    = '0;
          end else begin
            // FIFO mode searches only the head slot, which is then the pick.
            scan_n_nxt   = fifo_mode_r ? CNT_W'(1) : occ_r;
            scan_idx_nxt = '0;
            state_nxt    = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (scan_idx_r < scan_n_r) begin
          ram_re       = 1'b1;
          ram_raddr    = scan_idx_r[IDX_W-1:0];
          rd_vld_nxt   = 1'b1;
          rd_idx_nxt   = scan_idx_r[IDX_W-1:0];
          scan_idx_nxt = scan_idx_r + CNT_W'(1);
        end else if (!rd_vld_r) begin
          // The last slot has been compared; close the gap behind the pick.
          sh_rd_nxt = CNT_W'(best_idx) + CNT_W'(1);
          state_nxt = S_SHIFT;
        end
      end

      S_SHIFT: begin
        // Slot i+1 read in the previous cycle is written back to slot i.
        if (rd_vld_r) begin
          ram_we    = 1'b1;
          ram_waddr = rd_idx_r - IDX_W'(1);
        end
        if (sh_rd_r < occ_r) begin
          ram_re     = 1'b1;
          ram_raddr  = sh_rd_r[IDX_W-1:0];
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = sh_rd_r[IDX_W-1:0];
          sh_rd_nxt  = sh_rd_r + CNT_W'(1);
        end else if (!rd_vld_r) begin
          occ_nxt          = occ_r - CNT_W'(1);
          out_valid_nxt    = 1'b1;
          out_status_nxt   = ST_DEQUEUED;
          out_handle_nxt   = best.handle;
          out_priority_nxt = best.prio;
          out_count_nxt    = occ_r - CNT_W'(1);
          state_nxt        = S_IDLE;
        end
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_handle      = out_handle_r;
  assign out_priority    = out_priority_r;
  assign out_entry_count = out_count_r;

  `PPQ_ASSERT_IMPL(a_occ_bound, clk, rst_n, 1'b1, occ_r <= CNT_W'(QUEUE_DEPTH), "occupancy above depth")
  `PPQ_ASSERT_IMPL(a_no_result_busy, clk, rst_n, state_r != S_IDLE, !out_valid_r, "result while dequeue runs")
  `PPQ_ASSERT_IMPL(a_shift_write_range, clk, rst_n, ram_we && (state_r == S_SHIFT), CNT_W'(rd_idx_r) < occ_r, "shift writes past occupancy")
  `PPQ_ASSERT_NEXT(a_deq_count, clk, rst_n, out_valid_nxt && (state_r == S_SHIFT), occ_r == ($past(occ_r) - CNT_W'(1)), "dequeue did not drop occupancy by one")

endmodule

[sv/ppq_ram.sv]
module ppq_ram #(
  parameter int DATA_W = 24,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/ppq_min_unit.sv]
module ppq_min_unit
  import ppq_pkg::*;
(
  input  logic             clk,
  input  min_ctl_t         ctl,
  input  entry_t           data,
  output entry_t           best,
  output logic [IDX_W-1:0] best_idx
);

  entry_t           best_r;
  logic [IDX_W-1:0] best_idx_r;
  logic             take;

  // A strict compare keeps the entry nearest the head on a tie.
  assign take = ctl.vld && (ctl.first || (data.prio < best_r.prio));

  always_ff @(posedge clk) begin
    if (take) begin
      best_r     <= data;
      best_idx_r <= ctl.idx;
    end
  end

  assign best     = best_r;
  assign best_idx = best_idx_r;

endmodule

[bench/tb_process_priority_queue_core.sv]
module tb_process_priority_queue_core;
  import ppq_pkg::*;

  // The random traffic is sized to give exactly this many requests.
  localparam int RANDOM_REQUESTS = 1030;
  // This is longer than the slowest dequeue, so it covers any tail of work.
  localparam int SETTLE_CYCLES   = 40;
  // This is far above the slowest legal run.
  localparam int TIMEOUT_UNITS   = 10_000_000;

  // Each plan step is a request, a mode write, or a pause that waits until
  // the queue core has returned every result it owes.
  typedef enum logic [1:0] {
    DO_REQUEST,
    DO_MODE_WRITE,
    DO_QUIESCE
  } step_kind_t;

  typedef struct {
    step_kind_t               kind;
    opcode_t                  op;
    logic [HANDLE_BITS-1:0]   handle;
    logic [PRIORITY_BITS-1:0] prio;
    logic                     mode;
    int                       idle;
  } step_t;

  // This is one result as the core should report it.
  typedef struct packed {
    status_t                  status;
    logic [HANDLE_BITS-1:0]   handle;
    logic [PRIORITY_BITS-1:0] prio;
    logic [CNT_W-1:0]         count;
  } outcome_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     in_opcode = 1'b0;
  logic [HANDLE_BITS-1:0]   in_process_handle = '0;
  logic [PRIORITY_BITS-1:0] in_process_priority = '0;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic                     cfg_fifo_mode = 1'b0;
  logic                     out_valid;
  logic [1:0]               out_status;
  logic [HANDLE_BITS-1:0]   out_handle;
  logic [PRIORITY_BITS-1:0] out_priority;
  logic [CNT_W-1:0]         out_entry_count;

  process_priority_queue_core uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_opcode           (in_opcode),
    .in_process_handle   (in_process_handle),
    .in_process_priority (in_process_priority),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_fifo_mode       (cfg_fifo_mode),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_handle          (out_handle),
    .out_priority        (out_priority),
    .out_entry_count     (out_entry_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // The plan holds the steps still to drive. The other queue holds the
  // results that the core still owes, oldest first.
  step_t    plan[$];
  outcome_t owed_results[$];

  // This is the shadow copy of the queue contents, kept in the core's own
  // slot order. Entry 0 is the head, and only the entries below held_count
  // carry data.
  logic [HANDLE_BITS-1:0]   slot_handle [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] slot_prio   [QUEUE_DEPTH];
  int                       held_count = 0;
  logic                     serve_oldest = 1'b0;

  // The two counters below move by nonblocking assignment, so the driver and
  // the end-of-test logic read settled values at every clock edge.
  int requests_taken = 0;
  int results_seen   = 0;
  int mismatches     = 0;
  int mode_writes    = 0;
  int status_tally [4] = '{0, 0, 0, 0};
  int peak_fill      = 0;

  // This applies one accepted request to the shadow queue and returns the
  // result it must produce. An enqueue lands at the tail unless every slot is
  // taken. A dequeue takes the head in FIFO mode. Otherwise it takes the
  // lowest priority value, and on a tie the copy nearest the head wins.
  // Later slots then close the gap. A dequeue on an empty queue reports empty.
  function automatic outcome_t serve_request(opcode_t op, logic [HANDLE_BITS-1:0] h,
                                             logic [PRIORITY_BITS-1:0] p);
    outcome_t res;
    int       pick;
    res.handle = '0;
    res.prio   = '0;
    if (op == OP_ENQ) begin
      if (held_count < QUEUE_DEPTH) begin
        slot_handle[held_count] = h;
        slot_prio[held_count]   = p;
        held_count++;
        res.status = ST_ENQUEUED;
      end else begin
        res.status = ST_FULL;
      end
    end else if (held_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      pick = 0;
      if (!serve_oldest) begin
        for (int i = 1; i < held_count; i++) begin
          if (slot_prio[i] < slot_prio[pick]) pick = i;
        end
      end
      res.handle = slot_handle[pick];
      res.prio   = slot_prio[pick];
      for (int i = pick; i + 1 < held_count; i++) begin
        slot_handle[i] = slot_handle[i + 1];
        slot_prio[i]   = slot_prio[i + 1];
      end
      held_count--;
      res.status = ST_DEQUEUED;
    end
    res.count = CNT_W'(held_count);
    status_tally[int'(res.status)]++;
    if (held_count > peak_fill) peak_fill = held_count;
    return res;
  endfunction

  // The driver works from the head of the plan. All outgoing values are first
  // worked out in locals, and each port then gets at most one nonblocking
  // write per edge. This way a start that stays high for back-to-back
  // requests never drops and rises within the same time step.
  always @(posedge clk) begin : drive_proc
    logic next_start;
    logic next_cfg_valid;
    logic drive_fields;
    logic drive_mode;
    if (!rst_n) begin
      start     <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      next_start     = start;
      next_cfg_valid = cfg_valid;
      drive_fields   = 1'b0;
      drive_mode     = 1'b0;
      // A request is taken when start is high and busy is low. The
      // prediction is made at the moment the request is taken.
      if (start && !busy) begin
        owed_results.push_back(serve_request(opcode_t'(in_opcode), in_process_handle,
                                             in_process_priority));
        requests_taken <= requests_taken + 1;
        next_start = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        serve_oldest = cfg_fifo_mode;
        mode_writes++;
        next_cfg_valid = 1'b0;
      end
      if (!next_start && !next_cfg_valid && plan.size() > 0) begin
        case (plan[0].kind)
          DO_REQUEST: begin
            if (plan[0].idle > 0) begin
              plan[0].idle = plan[0].idle - 1;
            end else begin
              next_start   = 1'b1;
              drive_fields = 1'b1;
            end
          end
          DO_MODE_WRITE: begin
            next_cfg_valid = 1'b1;
            drive_mode     = 1'b1;
          end
          default: begin
            // Hold here until every request has reported back. Then allow
            // a short settle period before the step is released.
            if (results_seen >= requests_taken && !busy) begin
              if (plan[0].idle > 0) plan[0].idle = plan[0].idle - 1;
              else void'(plan.pop_front());
            end
          end
        endcase
      end
      if (drive_fields) begin
        in_opcode           <= plan[0].op;
        in_process_handle   <= plan[0].handle;
        in_process_priority <= plan[0].prio;
        void'(plan.pop_front());
      end
      if (drive_mode) begin
        cfg_fifo_mode <= plan[0].mode;
        void'(plan.pop_front());
      end
      start     <= next_start;
      cfg_valid <= next_cfg_valid;
    end
  end

  // The monitor takes each result that carries a strobe and checks it
  // against the oldest prediction still waiting.
  always @(posedge clk) begin : check_proc
    outcome_t want;
    if (rst_n && out_valid) begin
      results_seen <= results_seen + 1;
      if (owed_results.size() == 0) begin
        $error("unexpected result: status %0d handle %h priority %h count %0d",
               out_status, out_handle, out_priority, out_entry_count);
        mismatches++;
      end else begin
        want = owed_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          mismatches++;
        end
        if (out_handle !== want.handle) begin
          $error("out_handle: expected %h, got %h", want.handle, out_handle);
          mismatches++;
        end
        if (out_priority !== want.prio) begin
          $error("out_priority: expected %h, got %h", want.prio, out_priority);
          mismatches++;
        end
        if (out_entry_count !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, out_entry_count);
          mismatches++;
        end
      end
    end
  end

  // Most idle gaps are short and a few are long. A long gap that lands
  // during a dequeue leaves the core idle for a while after it finishes.
  function automatic int pick_idle();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  // The priority mix includes the extreme values and a narrow band that
  // makes ties likely. Ties are what test the nearest-to-head rule.
  function automatic logic [PRIORITY_BITS-1:0] pick_prio();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return '0;
    if (roll < 30) return '1;
    if (roll < 65) return PRIORITY_BITS'($urandom_range(0, 3));
    return PRIORITY_BITS'($urandom);
  endfunction

  function automatic logic [HANDLE_BITS-1:0] pick_handle();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return '0;
    if (roll < 10) return '1;
    return HANDLE_BITS'($urandom);
  endfunction

  function automatic void add_request(opcode_t op, logic [HANDLE_BITS-1:0] h,
                                      logic [PRIORITY_BITS-1:0] p, int idle);
    step_t s;
    s.kind   = DO_REQUEST;
    s.op     = op;
    s.handle = h;
    s.prio   = p;
    s.mode   = 1'b0;
    s.idle   = idle;
    plan.push_back(s);
  endfunction

  // A mode change is only legal while no request is in flight, so a
  // quiesce step always goes ahead of it.
  function automatic void add_mode_write(logic mode);
    step_t s;
    s.kind   = DO_QUIESCE;
    s.op     = OP_ENQ;
    s.handle = '0;
    s.prio   = '0;
    s.mode   = 1'b0;
    s.idle   = 4;
    plan.push_back(s);
    s.kind = DO_MODE_WRITE;
    s.mode = mode;
    s.idle = 0;
    plan.push_back(s);
  endfunction

  initial begin : stimulus_proc
    logic [PRIORITY_BITS-1:0] fill_prio [16];
    logic [HANDLE_BITS-1:0]   fill_handle [16];
    int remaining;
    int phase;
    int span;
    int enq_pct;
    int steady;
    opcode_t op;

    fill_prio   = '{8'h80, 8'h00, 8'hFF, 8'h00, 8'h55, 8'hAA, 8'h01, 8'hFE,
                    8'h00, 8'h7F, 8'h10, 8'h10, 8'hFF, 8'h02, 8'h40, 8'h20};
    fill_handle = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h1111, 16'h2222,
                    16'h3333, 16'h4444, 16'h8001, 16'h7FFE, 16'h00FF, 16'hFF00,
                    16'h0F0F, 16'hF0F0, 16'h1234, 16'hFEDC};

    // The directed part runs in priority mode right after reset. It starts
    // with a dequeue on an empty queue. Next it fills every slot with
    // extreme values and repeated lowest priorities, and then pushes one more
    // request to hit the full case. A few priority dequeues follow, and the
    // first of them land on ties.
    add_request(OP_DEQ, 16'hFFFF, 8'hFF, 0);
    for (int i = 0; i < 16; i++) begin
      add_request(OP_ENQ, fill_handle[i], fill_prio[i], i % 3 == 0 ? 1 : 0);
    end
    add_request(OP_ENQ, 16'hBEEF, 8'h00, 0);
    for (int i = 0; i < 4; i++) add_request(OP_DEQ, '0, '0, 0);
    // Switch to FIFO mode while the queue still holds entries. The head
    // now comes out regardless of its priority.
    add_mode_write(1'b1);
    for (int i = 0; i < 3; i++) add_request(OP_DEQ, '1, '1, i);

    // The random part runs in phases. Each phase sets a mode and a bias
    // toward enqueues or dequeues, so the queue swings between full and
    // empty under both service orders. Some phases drive requests back to
    // back with no idle gaps at all.
    remaining = RANDOM_REQUESTS;
    phase     = 0;
    while (remaining > 0) begin
      span = $urandom_range(60, 160);
      if (span > remaining) span = remaining;
      add_mode_write(phase < 2 ? logic'(phase) : logic'($urandom_range(0, 1)));
      case ($urandom_range(0, 2))
        0:       enq_pct = 80;
        1:       enq_pct = 25;
        default: enq_pct = 55;
      endcase
      steady = ($urandom_range(0, 2) == 0);
      for (int k = 0; k < span; k++) begin
        op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
        add_request(op, pick_handle(), pick_prio(), steady ? 0 : pick_idle());
      end
      remaining -= span;
      phase++;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the plan to run out and for every owed result to arrive.
    // After that, wait out SETTLE_CYCLES so that any stray strobe shows up.
    while (plan.size() > 0 || start || cfg_valid || results_seen < requests_taken)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (owed_results.size() != 0) begin
      $error("%0d expected results never arrived", owed_results.size());
      mismatches++;
    end
    $display("Ran %0d requests over %0d mode writes, with up to %0d entries held.",
             requests_taken, mode_writes, peak_fill);
    $display("Outcomes: %0d enqueued, %0d dropped full, %0d served, %0d on empty.",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3]);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog_proc
    #(TIMEOUT_UNITS);
    $display("Timeout with %0d results still owed.", owed_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/ppq_pkg.sv
sv/ppq_ram.sv
sv/ppq_min_unit.sv
sv/process_priority_queue_core.sv
bench/tb_process_priority_queue_core.sv
